/* src/tskf_pkg.sv */
// ----------------------------------------------------------------------------
// tskf_pkg
// Shared widths, constants and control types for the three-axis scalar
// Kalman filter.
// ----------------------------------------------------------------------------
package tskf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int REG_W     = 24;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 4;
  localparam int EST_W     = SAMPLE_W + FRAC_BITS;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = REG_W + 1;
  localparam int PROD_W    = EST_W + GAIN_W;
  localparam int CPROD_W   = REG_W + GAIN_W;
  localparam int CNT_W     = $clog2(GAIN_W + 1);
  localparam int RND_W     = EST_W + 2;

  localparam logic [GAIN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam longint REG_MAX = (64'sd1 <<< REG_W) - 64'sd1;
  localparam longint Q_RAW   = (64'sd1 <<< FRAC_BITS) >>> 4;
  localparam longint R_RAW   = 64'sd1 <<< FRAC_BITS;
  localparam longint P_RAW   = ((64'sd22 <<< FRAC_BITS) + 64'sd50) / 64'sd100;

  localparam logic [REG_W-1:0] Q_RESET =
    (Q_RAW > REG_MAX) ? REG_MAX[REG_W-1:0] : Q_RAW[REG_W-1:0];
  localparam logic [REG_W-1:0] R_RESET =
    (R_RAW > REG_MAX) ? REG_MAX[REG_W-1:0] : R_RAW[REG_W-1:0];
  localparam logic [REG_W-1:0] P_RESET =
    (P_RAW > REG_MAX) ? REG_MAX[REG_W-1:0] : P_RAW[REG_W-1:0];

  // rounding offsets: +0.5, and +0.5 + (1.0 - lsb) for truncation toward zero
  localparam longint RND_POS_RAW = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint RND_NEG_RAW = RND_POS_RAW + (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic [RND_W-1:0] RND_POS = RND_POS_RAW[RND_W-1:0];
  localparam logic [RND_W-1:0] RND_NEG = RND_NEG_RAW[RND_W-1:0];

  localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [1:0] REG_Q  = 2'd0;
  localparam logic [1:0] REG_R  = 2'd1;
  localparam logic [1:0] REG_P0 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSUM,
    ST_DIVS,
    ST_DIVW,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic diff;
    logic mul;
    logic upd;
    logic echo;
  } lane_ctl_t;

endpackage

/* src/tskf_div.sv */
// ----------------------------------------------------------------------------
// tskf_div
// Restoring serial divider for the Kalman gain: quot = (num << FRAC_BITS)/den,
// one quotient bit per cycle, num <= den assumed. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module tskf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tskf_pkg::REG_W-1:0]   num,
  input  logic [tskf_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [tskf_pkg::GAIN_W-1:0]  quot
);
  import tskf_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              first;
  logic              zero;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] quot_r;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    sub;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  always_comb begin
    trial    = first ? {1'b0, rem} : {rem, 1'b0};
    ge       = trial >= {1'b0, den_r};
    sub      = trial - {1'b0, den_r};
    rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      first  <= 1'b1;
      zero   <= (den == '0);
      rem    <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy) begin
      first  <= 1'b0;
      rem    <= rem_next;
      quot_r <= {quot_r[GAIN_W-2:0], ge};
    end
  end

  assign quot = zero ? '0 : quot_r;

endmodule

/* src/tskf_lane.sv */
// ----------------------------------------------------------------------------
// tskf_lane
// One axis: holds the fixed-point estimate, forms |sample - estimate|,
// scales it by the gain, steps toward the sample and rounds for output.
// ----------------------------------------------------------------------------
module tskf_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  tskf_pkg::lane_ctl_t                 ctl,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [tskf_pkg::GAIN_W-1:0]         gain,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] filtered
);
  import tskf_pkg::*;

  logic [SAMPLE_W-1:0] sample;
  logic [EST_W-1:0]    est;
  logic [EST_W-1:0]    mag;
  logic                neg;
  logic [PROD_W-1:0]   prod;

  logic [EST_W:0]      diff_w;
  logic [EST_W:0]      mag_w;
  logic [EST_W-1:0]    step;
  logic [RND_W-1:0]    est_x;
  logic [RND_W-1:0]    v_pos;
  logic [RND_W-1:0]    v_neg;
  logic [RND_W-1:0]    v_sel;
  logic [SAMPLE_W+1:0] r_int;
  logic [SAMPLE_W-1:0] r_sat;

  always_comb begin
    diff_w = {sample[SAMPLE_W-1], sample, {FRAC_BITS{1'b0}}} - {est[EST_W-1], est};
    mag_w  = diff_w[EST_W] ? (~diff_w + 1'b1) : diff_w;
    step   = prod[EST_W+FRAC_BITS-1:FRAC_BITS];

    est_x  = {{2{est[EST_W-1]}}, est};
    v_pos  = est_x + RND_POS;
    v_neg  = est_x + RND_NEG;
    v_sel  = v_pos[RND_W-1] ? v_neg : v_pos;
    r_int  = v_sel[RND_W-1:FRAC_BITS];
    if ((r_int[SAMPLE_W+1:SAMPLE_W-1] == 3'b000) ||
        (r_int[SAMPLE_W+1:SAMPLE_W-1] == 3'b111)) begin
      r_sat = r_int[SAMPLE_W-1:0];
    end else begin
      r_sat = r_int[SAMPLE_W+1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
    end else begin
      if (ctl.capture && ctl.load) begin
        est <= {sample_in, {FRAC_BITS{1'b0}}};
      end else if (ctl.upd) begin
        est <= neg ? (est - step) : (est + step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      sample <= sample_in;
    end
    if (ctl.diff) begin
      mag <= mag_w[EST_W-1:0];
      neg <= diff_w[EST_W];
    end
    if (ctl.mul) begin
      prod <= mag * gain;
    end
  end

  assign filtered = ctl.echo ? sample : r_sat;

endmodule

/* src/three_axis_scalar_kalman_filter.sv */
// ----------------------------------------------------------------------------
// three_axis_scalar_kalman_filter
// Three-axis scalar Kalman smoother with a shared error covariance,
// APB-style register port and valid/ready sample and result channels.
//
//   channel   | signals                                   | dir
//   ----------+-------------------------------------------+-----
//   config    | psel penable pwrite paddr pwdata prdata   | in/out
//   sample    | sample_valid sample_ready sample_x/y/z    | in
//   filtered  | filtered_valid filtered_ready filtered_x/y/z | out
//
// Priming beat: accept leads straight to ST_FIN, which registers the echoed
// sample. Other beats pass ST_PSUM, ST_DIVS, ST_DIVW (17-step serial gain
// divider), ST_MUL, ST_UPD and ST_FIN; samples are taken only in ST_IDLE.
// Reset: synchronous, no clearing pass; sample_ready stays low during rst.
// A finished result waits in the output register while the next beat is
// taken; the core only waits when that register is still occupied.
// ----------------------------------------------------------------------------
module three_axis_scalar_kalman_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tskf_pkg::ADDR_W-1:0]           paddr,
  input  logic [tskf_pkg::APB_W-1:0]            pwdata,
  output logic [tskf_pkg::APB_W-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0]  sample_y,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0]  sample_z,
  output logic                                  filtered_valid,
  input  logic                                  filtered_ready,
  output logic signed [tskf_pkg::SAMPLE_W-1:0]  filtered_x,
  output logic signed [tskf_pkg::SAMPLE_W-1:0]  filtered_y,
  output logic signed [tskf_pkg::SAMPLE_W-1:0]  filtered_z
);
  import tskf_pkg::*;

  logic [REG_W-1:0]    process_noise;
  logic [REG_W-1:0]    measurement_noise;
  logic [REG_W-1:0]    initial_covariance;

  state_t              state;
  state_t              state_next;
  logic                primed;
  logic                item_prime;
  logic [REG_W-1:0]    error_covariance;
  logic [REG_W-1:0]    p_cur;
  logic [CPROD_W-1:0]  cov_prod;

  logic                accept;
  logic                cfg_wr;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [GAIN_W-1:0]   gain;
  logic [REG_W:0]      psum;
  logic [REG_W-1:0]    p_sat;
  logic [DEN_W-1:0]    den;
  lane_ctl_t           lane_ctl;
  logic [SAMPLE_W-1:0] lane_x;
  logic [SAMPLE_W-1:0] lane_y;
  logic [SAMPLE_W-1:0] lane_z;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= Q_RESET;
      measurement_noise  <= R_RESET;
      initial_covariance <= P_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_Q:   process_noise      <= pwdata[REG_W-1:0];
        REG_R:   measurement_noise  <= pwdata[REG_W-1:0];
        REG_P0:  initial_covariance <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_Q:   prdata = {{(APB_W-REG_W){1'b0}}, process_noise};
      REG_R:   prdata = {{(APB_W-REG_W){1'b0}}, measurement_noise};
      REG_P0:  prdata = {{(APB_W-REG_W){1'b0}}, initial_covariance};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    psum  = {1'b0, error_covariance} + {1'b0, process_noise};
    p_sat = psum[REG_W] ? {REG_W{1'b1}} : psum[REG_W-1:0];
    den   = {1'b0, p_cur} + {1'b0, measurement_noise};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = primed ? ST_PSUM : ST_FIN;
      ST_PSUM: state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: if (div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_FIN;
      ST_FIN:  if (!filtered_valid || filtered_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready     = (state == ST_IDLE) && !rst;
    div_start        = (state == ST_DIVS);
    out_load         = (state == ST_FIN) && (!filtered_valid || filtered_ready);
    lane_ctl.capture = accept;
    lane_ctl.load    = !primed;
    lane_ctl.diff    = (state == ST_PSUM);
    lane_ctl.mul     = (state == ST_MUL);
    lane_ctl.upd     = (state == ST_UPD);
    lane_ctl.echo    = item_prime;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      primed           <= 1'b0;
      item_prime       <= 1'b0;
      filtered_valid   <= 1'b0;
      error_covariance <= P_RESET;
    end else begin
      state <= state_next;
      if (accept) begin
        primed     <= 1'b1;
        item_prime <= !primed;
        if (!primed) begin
          error_covariance <= initial_covariance;
        end
      end
      if (state == ST_UPD) begin
        error_covariance <= cov_prod[REG_W+FRAC_BITS-1:FRAC_BITS];
      end
      if (out_load) begin
        filtered_valid <= 1'b1;
      end else if (filtered_ready) begin
        filtered_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PSUM) begin
      p_cur <= p_sat;
    end
    if (state == ST_MUL) begin
      cov_prod <= (ONE - gain) * p_cur;
    end
    if (out_load) begin
      filtered_x <= lane_x;
      filtered_y <= lane_y;
      filtered_z <= lane_z;
    end
  end

  tskf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p_cur),
    .den   (den),
    .done  (div_done),
    .quot  (gain)
  );

  tskf_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample_in (sample_x),
    .gain      (gain),
    .filtered  (lane_x)
  );

  tskf_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample_in (sample_y),
    .gain      (gain),
    .filtered  (lane_y)
  );

  tskf_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample_in (sample_z),
    .gain      (gain),
    .filtered  (lane_z)
  );

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("gain divider finished outside its wait state");

  a_prime_once: assert property (@(posedge clk) disable iff (rst)
    (accept && !primed) |=> (primed && item_prime && (state == ST_FIN)))
    else $error("priming beat did not go straight to output");

  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (gain <= ONE))
    else $error("gain above one");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |=> (error_covariance <= $past(p_cur)))
    else $error("covariance grew in update");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis scalar Kalman filter. Drives
// samples over valid/ready, programs the noise registers over APB and
// compares every filtered beat against a fixed-point model of the filter
// kept in the bench. Covers the priming beat, sample extremes, unity and
// zero gain, covariance saturation, long random runs under several noise
// settings, and a full output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import tskf_pkg::*;

  localparam longint unsigned UNITY    = 64'd1 << FRAC_BITS;
  localparam longint unsigned REG_FULL = (64'd1 << REG_W) - 64'd1;
  localparam longint          HALF     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint          OUT_MAX  = 32767;
  localparam longint          OUT_MIN  = -32768;
  localparam logic [1:0]        REG_UNUSED = 2'd3;
  localparam logic [REG_W-1:0]  REG_TOP    = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } axis_triple_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [APB_W-1:0]           pwdata;
  logic [APB_W-1:0]           prdata;
  logic                       pready;
  logic                       sample_valid;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;
  logic                       filtered_valid;
  logic                       filtered_ready;
  logic signed [SAMPLE_W-1:0] filtered_x;
  logic signed [SAMPLE_W-1:0] filtered_y;
  logic signed [SAMPLE_W-1:0] filtered_z;

  // bench copy of the filter state and registers
  logic [REG_W-1:0] q_reg;
  logic [REG_W-1:0] r_reg;
  logic [REG_W-1:0] p0_reg;
  logic             est_loaded;
  longint           est_acc [3];
  longint unsigned  cov_p;

  axis_triple_t expected_filtered [$];
  axis_triple_t head;

  int  err_count;
  int  sent_beats;
  int  checked_beats;
  int  cfg_writes;
  int  in_stall_cycles;
  int  hold_req;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  drift [3];

  three_axis_scalar_kalman_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample_x       (sample_x),
    .sample_y       (sample_y),
    .sample_z       (sample_z),
    .filtered_valid (filtered_valid),
    .filtered_ready (filtered_ready),
    .filtered_x     (filtered_x),
    .filtered_y     (filtered_y),
    .filtered_z     (filtered_z)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 40) begin
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] corner_value(int i);
    case (i)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      5: return 16'sh5555;
      default: return 16'shAAAA;
    endcase
  endfunction

  function automatic axis_triple_t kalman_predict(axis_triple_t smp);
    axis_triple_t res;
    logic signed [SAMPLE_W-1:0] raw [3];
    logic signed [SAMPLE_W-1:0] rnd [3];
    longint unsigned p_sum, den, gain, mag, step;
    longint target, diff, biased, whole;
    raw[0] = smp.x;
    raw[1] = smp.y;
    raw[2] = smp.z;
    if (!est_loaded) begin
      est_loaded = 1'b1;
      cov_p = 64'(p0_reg);
      for (int i = 0; i < 3; i++) begin
        est_acc[i] = longint'(raw[i]) <<< FRAC_BITS;
        rnd[i] = raw[i];
      end
    end else begin
      p_sum = cov_p + q_reg;
      if (p_sum > REG_FULL) p_sum = REG_FULL;
      den = p_sum + r_reg;
      gain = '0;
      if (den != 0) gain = (p_sum << FRAC_BITS) / den;
      if (gain > UNITY) gain = UNITY;
      for (int i = 0; i < 3; i++) begin
        target = longint'(raw[i]) <<< FRAC_BITS;
        diff = target - est_acc[i];
        mag = (diff >= 0) ? diff : -diff;
        step = (mag * gain) >> FRAC_BITS;
        if (diff >= 0) est_acc[i] = est_acc[i] + longint'(step);
        else est_acc[i] = est_acc[i] - longint'(step);
        biased = est_acc[i] + HALF;
        if (biased >= 0) whole = biased >>> FRAC_BITS;
        else whole = -((-biased) >>> FRAC_BITS);
        if (whole > OUT_MAX) whole = OUT_MAX;
        else if (whole < OUT_MIN) whole = OUT_MIN;
        rnd[i] = whole[SAMPLE_W-1:0];
      end
      cov_p = ((UNITY - gain) * p_sum) >> FRAC_BITS;
    end
    res.x = rnd[0];
    res.y = rnd[1];
    res.z = rnd[2];
    return res;
  endfunction

  // result checker and input stall counter
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_ready) in_stall_cycles++;
      if (filtered_valid && filtered_ready) begin
        if (expected_filtered.size() == 0) begin
          report_mismatch("filtered beat with nothing pending", 1, 0);
        end else begin
          head = expected_filtered.pop_front();
          checked_beats++;
          if (filtered_x !== head.x) begin
            report_mismatch("filtered_x", int'(filtered_x), int'(head.x));
          end
          if (filtered_y !== head.y) begin
            report_mismatch("filtered_y", int'(filtered_y), int'(head.y));
          end
          if (filtered_z !== head.z) begin
            report_mismatch("filtered_z", int'(filtered_z), int'(head.z));
          end
        end
      end
    end
  end

  // result receiver
  initial begin : sink
    int ready_gap;
    filtered_ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        ready_gap = hold_req;
        hold_req = 0;
      end else begin
        ready_gap = sink_idle_en ? $urandom_range(0, 12) : 0;
      end
      if (ready_gap > 0) begin
        filtered_ready <= 1'b0;
        repeat (ready_gap) @(posedge clk);
      end
      filtered_ready <= 1'b1;
      @(posedge clk);
      while (!filtered_valid) @(posedge clk);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [REG_W-1:0] val);
    logic [APB_W-1:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[APB_W-1:REG_W], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_Q:   q_reg = val;
      REG_R:   r_reg = val;
      REG_P0:  p0_reg = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(logic [1:0] idx);
    logic [REG_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_Q:   want = q_reg;
      REG_R:   want = r_reg;
      default: want = p0_reg;
    endcase
    if (prdata !== {{(APB_W-REG_W){1'b0}}, want}) begin
      report_mismatch("prdata", int'(prdata), int'(want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy,
                             input logic signed [SAMPLE_W-1:0] sz);
    int gap;
    axis_triple_t s;
    gap = src_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_x     <= sx;
    sample_y     <= sy;
    sample_z     <= sz;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    s.x = sx;
    s.y = sy;
    s.z = sz;
    expected_filtered.push_back(kalman_predict(s));
    sent_beats++;
  endtask

  task automatic wait_results_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_filtered.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_access();
    cfg_read_check(REG_Q);
    cfg_read_check(REG_R);
    cfg_read_check(REG_P0);
    cfg_write(REG_P0, 24'd20000);
    cfg_write(REG_Q, Q_RESET);
    cfg_write(REG_R, R_RESET);
    cfg_write(REG_UNUSED, REG_TOP);
    cfg_read_check(REG_Q);
    cfg_read_check(REG_R);
    cfg_read_check(REG_P0);
  endtask

  task automatic test_priming_beat();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF);
    wait_results_drained();
  endtask

  task automatic test_field_extremes();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_sample(corner_value(i % 7), corner_value((i + 3) % 7), corner_value((i + 5) % 7));
    end
    wait_results_drained();
  endtask

  task automatic test_gain_corners();
    // unity gain: r = 0
    cfg_write(REG_R, '0);
    cfg_read_check(REG_R);
    send_sample(16'sh1234, 16'shEDCB, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh0000, 16'sh0001);
    send_sample(16'sh0100, 16'shFF00, 16'sh4000);
    wait_results_drained();
    // p is now zero; with q = 0 too the gain denominator is zero
    cfg_write(REG_Q, '0);
    cfg_read_check(REG_Q);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh5555);
    send_sample(16'shAAAA, 16'sh0001, 16'shFFFF);
    send_sample(16'sh0000, 16'sh7FFF, 16'sh8000);
    wait_results_drained();
    // covariance saturation
    cfg_write(REG_Q, REG_TOP);
    cfg_write(REG_R, REG_TOP);
    cfg_read_check(REG_Q);
    cfg_read_check(REG_R);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh5555, 16'shAAAA);
    wait_results_drained();
    cfg_write(REG_Q, Q_RESET);
    cfg_write(REG_R, R_RESET);
  endtask

  task automatic test_random_tracking();
    logic [REG_W-1:0] qv;
    logic [REG_W-1:0] rv;
    logic signed [SAMPLE_W-1:0] s [3];
    int pick;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin qv = Q_RESET; rv = R_RESET; end
        1: begin qv = '0; rv = REG_W'($urandom_range(1, 1 << 20)); end
        2: begin qv = REG_TOP; rv = '0; end
        3: begin
          qv = REG_W'($urandom_range(0, 1 << 16));
          rv = REG_W'($urandom());
        end
        4: begin qv = REG_W'($urandom_range(0, 1 << 18)); rv = REG_TOP; end
        5: begin qv = '0; rv = '0; end
        6: begin qv = REG_W'($urandom()); rv = REG_W'($urandom()); end
        default: begin
          qv = REG_W'($urandom_range(1, 1 << 12));
          rv = REG_W'($urandom_range(1, 1 << 17));
        end
      endcase
      cfg_write(REG_Q, qv);
      cfg_write(REG_R, rv);
      cfg_write(REG_P0, REG_W'($urandom()));
      cfg_read_check(REG_Q);
      cfg_read_check(REG_R);
      cfg_read_check(REG_P0);
      src_idle_en = ((ph % 2) != 0);
      sink_idle_en = (((ph / 2) % 2) != 0);
      for (int n = 0; n < 205; n++) begin
        pick = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
          if (pick < 65) begin
            drift[a] = int'(clip16(drift[a] + int'($urandom_range(0, 400)) - 200));
            s[a] = clip16(drift[a] + int'($urandom_range(0, 64)) - 32);
          end else if (pick < 90) begin
            s[a] = SAMPLE_W'($urandom());
          end else begin
            s[a] = corner_value($urandom_range(0, 6));
          end
        end
        send_sample(s[0], s[1], s[2]);
      end
      wait_results_drained();
    end
  endtask

  task automatic test_output_backpressure();
    cfg_write(REG_Q, Q_RESET);
    cfg_write(REG_R, R_RESET);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b1;
    hold_req = 400;
    for (int n = 0; n < 40; n++) begin
      send_sample(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
    end
    wait_results_drained();
  endtask

  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample_x     = '0;
    sample_y     = '0;
    sample_z     = '0;
    q_reg        = Q_RESET;
    r_reg        = R_RESET;
    p0_reg       = P_RESET;
    est_loaded   = 1'b0;
    cov_p        = 64'(P_RESET);
    for (int a = 0; a < 3; a++) begin
      est_acc[a] = '0;
      drift[a] = 0;
    end
    err_count       = 0;
    sent_beats      = 0;
    checked_beats   = 0;
    cfg_writes      = 0;
    in_stall_cycles = 0;
    hold_req        = 0;
    src_idle_en     = 1'b0;
    sink_idle_en    = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_priming_beat();
    test_field_extremes();
    test_gain_corners();
    test_random_tracking();
    test_output_backpressure();

    wait_results_drained();
    repeat (40) @(posedge clk);
    $display("summary: %0d sample beats sent, %0d filtered beats checked, %0d register writes",
             sent_beats, checked_beats, cfg_writes);
    $display("summary: gains from zero to unity, saturated covariance, input held %0d cycles",
             in_stall_cycles);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
